// ===== rtl/kmdeq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths, register indexes and reset values for the key matrix
// debounce and event queue block. No dependencies.
package kmdeq_pkg;

    // Parameter defaults
    localparam int ROWS_MAX_DEF    = 16;
    localparam int COLS_MAX_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths
    localparam int ROW_W      = 4;
    localparam int COL_W      = 4;
    localparam int LEVELS_W   = 16;
    localparam int TIME_W     = 32;
    localparam int CNT_CFG_W  = 5;
    localparam int LIM_W      = CNT_CFG_W + 1;
    localparam int CODE_W     = 8;
    localparam int MAP_AW     = 8;
    localparam int MAP_DEPTH  = 1 << MAP_AW;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_ENABLE = 2'd3;

    // Request types
    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_MAP  = 1'b1;

    // Register reset values
    localparam logic [CNT_CFG_W-1:0] ROW_COUNT_RST = 5'd16;
    localparam logic [CNT_CFG_W-1:0] COL_COUNT_RST = 5'd16;
    localparam logic [TIME_W-1:0]    DEBOUNCE_RST  = 32'd5;
    localparam logic                 MOD_EN_RST    = 1'b0;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CODE_W-1:0] keycode;
        logic [CODE_W-1:0] modifier;
        logic              pressed;
    } scan_event_t;

    typedef struct packed {
        logic              down;
        logic [TIME_W-1:0] stamp;
    } key_state_t;

    typedef struct packed {
        logic [CODE_W-1:0] keycode;
        logic [CODE_W-1:0] modifier;
    } map_entry_t;

endpackage

// ===== rtl/kmdeq_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: row scan samples and keymap writes.
// Depends on kmdeq_pkg.
interface kmdeq_req_if;
    import kmdeq_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [ROW_W-1:0]    row_index;
    logic [LEVELS_W-1:0] col_levels;
    logic [TIME_W-1:0]   now_ms;
    logic                scan_end;
    logic [MAP_AW-1:0]   map_index;
    logic [CODE_W-1:0]   map_keycode;
    logic [CODE_W-1:0]   map_modifier;

    modport source (
        output valid, req_type, row_index, col_levels, now_ms, scan_end,
               map_index, map_keycode, map_modifier,
        input  ready
    );

    modport sink (
        input  valid, req_type, row_index, col_levels, now_ms, scan_end,
               map_index, map_keycode, map_modifier,
        output ready
    );
endinterface

// ===== rtl/kmdeq_evt_if.sv =====
`timescale 1ns / 1ps
// Event channel: one popped key event per scan end.
// Depends on kmdeq_pkg.
interface kmdeq_evt_if;
    import kmdeq_pkg::*;

    logic              valid;
    logic              ready;
    logic              event_valid;
    logic [ROW_W-1:0]  event_row;
    logic [COL_W-1:0]  event_col;
    logic [CODE_W-1:0] event_keycode;
    logic [CODE_W-1:0] event_modifier;
    logic              event_pressed;

    modport source (
        output valid, event_valid, event_row, event_col, event_keycode,
               event_modifier, event_pressed,
        input  ready
    );

    modport sink (
        input  valid, event_valid, event_row, event_col, event_keycode,
               event_modifier, event_pressed,
        output ready
    );
endinterface

// ===== rtl/kmdeq_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on kmdeq_pkg.
interface kmdeq_cfg_if;
    import kmdeq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== rtl/kmdeq_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module kmdeq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/key_matrix_debounce_event_queue_core.sv =====
`timescale 1ns / 1ps
// Key matrix scanner with per-key debounce and a ring of key events.
// Depends on kmdeq_pkg, kmdeq_req_if, kmdeq_evt_if, kmdeq_cfg_if, kmdeq_ram.
//
//   channel  dir  handshake     word
//   req      in   valid/ready   scan sample or keymap write
//   evt      out  valid/ready   one popped event (or empty marker)
//   cfg      in   valid/ready   register index + data, always ready
//
// A scan word for a row in use is accepted, walks one column per cycle
// through the key state memory read port, then drains.
// A scan end adds the ring read (ST_POP_RD, then ST_POP_WAIT); keymap
// writes are taken in ST_IDLE. After reset a clearing pass zeroes all
// ROWS_MAX*COLS_MAX key state entries; req is held off meanwhile. A held
// evt word does not block the next scan, only the next pop.
module key_matrix_debounce_event_queue_core #(
    parameter int ROWS_MAX    = kmdeq_pkg::ROWS_MAX_DEF,
    parameter int COLS_MAX    = kmdeq_pkg::COLS_MAX_DEF,
    parameter int QUEUE_DEPTH = kmdeq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    kmdeq_req_if.sink   req,
    kmdeq_evt_if.source evt,
    kmdeq_cfg_if.sink   cfg
);
    import kmdeq_pkg::*;

    localparam int KEY_DEPTH = ROWS_MAX * COLS_MAX;
    localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int CNT_W     = $clog2(COLS_MAX + 1);
    localparam int QA_W      = $clog2(QUEUE_DEPTH);
    localparam int KS_W      = $bits(key_state_t);
    localparam int EV_W      = $bits(scan_event_t);
    localparam int ME_W      = $bits(map_entry_t);

    localparam logic [LIM_W-1:0]  ROWS_LIM  = LIM_W'(ROWS_MAX);
    localparam logic [LIM_W-1:0]  COLS_LIM  = LIM_W'(COLS_MAX);
    localparam logic [KEY_AW-1:0] KEY_LAST  = KEY_AW'(KEY_DEPTH - 1);
    localparam logic [QA_W-1:0]   RING_LAST = QA_W'(QUEUE_DEPTH - 1);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_POP_RD   = 3'd3;
    localparam logic [2:0] ST_POP_WAIT = 3'd4;

    // control registers
    logic [2:0]           state_reg, state_next;
    logic [KEY_AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [CNT_CFG_W-1:0] row_count_reg, col_count_reg;
    logic [TIME_W-1:0]    debounce_reg;
    logic                 mod_en_reg;
    logic [CNT_W-1:0]     issue_cnt_reg, issue_cnt_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [QA_W-1:0]      ring_head_reg, ring_head_next;
    logic [QA_W-1:0]      ring_tail_reg, ring_tail_next;
    logic                 evt_valid_reg, evt_valid_next;

    // payload registers
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [LEVELS_W-1:0]  lvl_reg, lvl_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic                 scan_end_reg, scan_end_next;
    logic [CNT_W-1:0]     cols_reg, cols_next;
    logic [KEY_AW-1:0]    key_addr_reg, key_addr_next;
    logic [MAP_AW-1:0]    map_addr_reg, map_addr_next;
    logic [COL_W-1:0]     col_tag_reg, col_tag_next;
    logic [COL_W-1:0]     ev_col_reg, ev_col_next;
    logic                 ev_pressed_reg, ev_pressed_next;
    logic [KEY_AW-1:0]    ev_key_addr_reg, ev_key_addr_next;
    logic                 pop_empty_reg, pop_empty_next;
    logic                 evt_flag_reg, evt_flag_next;
    scan_event_t          evt_data_reg, evt_data_next;

    // datapath
    logic                 req_fire;
    logic [LIM_W-1:0]     rows_lim, cols_lim;
    logic                 row_in_use;
    logic [31:0]          key_base_full;
    logic [ROW_W+LIM_W-1:0] map_prod;
    logic                 issue;
    logic                 key_change;
    logic                 ring_full;
    logic                 push;
    logic                 out_free;
    logic [QA_W-1:0]      head_inc, tail_inc;
    scan_event_t          push_ev;

    // memory ports
    logic                 key_we, key_re;
    logic [KEY_AW-1:0]    key_waddr;
    key_state_t           key_wdata, key_rdata;
    logic                 map_we;
    map_entry_t           map_wdata, map_rdata;
    logic                 ring_we, ring_re;
    scan_event_t          ring_rdata;

    kmdeq_ram #(.WIDTH(KS_W), .DEPTH(KEY_DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (key_addr_reg),
        .rdata (key_rdata)
    );

    kmdeq_ram #(.WIDTH(ME_W), .DEPTH(MAP_DEPTH)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (req.map_index),
        .wdata (map_wdata),
        .re    (key_re),
        .raddr (map_addr_reg),
        .rdata (map_rdata)
    );

    kmdeq_ram #(.WIDTH(EV_W), .DEPTH(QUEUE_DEPTH)) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_head_reg),
        .wdata (push_ev),
        .re    (ring_re),
        .raddr (ring_tail_reg),
        .rdata (ring_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rows_lim = ({1'b0, row_count_reg} > ROWS_LIM) ? ROWS_LIM : {1'b0, row_count_reg};
    assign cols_lim = ({1'b0, col_count_reg} > COLS_LIM) ? COLS_LIM : {1'b0, col_count_reg};
    assign row_in_use    = (LIM_W'(req.row_index) < rows_lim) && (cols_lim != '0);
    assign key_base_full = 32'(req.row_index) * 32'(COLS_MAX);
    assign map_prod      = (ROW_W+LIM_W)'(req.row_index) * (ROW_W+LIM_W)'(cols_lim);

    assign map_we    = req_fire && (req.req_type == REQ_MAP);
    assign map_wdata = '{keycode: req.map_keycode, modifier: req.map_modifier};

    assign issue  = (state_reg == ST_SCAN) && (issue_cnt_reg != cols_reg);
    assign key_re = issue;

    // evaluate the column whose state was read last cycle
    assign key_change = ev_valid_reg && (ev_pressed_reg != key_rdata.down) &&
                        ((now_reg - key_rdata.stamp) >= debounce_reg);

    assign head_inc  = (ring_head_reg == RING_LAST) ? '0 : ring_head_reg + 1'b1;
    assign tail_inc  = (ring_tail_reg == RING_LAST) ? '0 : ring_tail_reg + 1'b1;
    assign ring_full = (head_inc == ring_tail_reg);
    assign push      = key_change;
    assign ring_we   = push && !ring_full;
    assign ring_re   = (state_reg == ST_POP_RD) && (ring_head_reg != ring_tail_reg);

    assign push_ev = '{row:      row_reg,
                       col:      ev_col_reg,
                       keycode:  map_rdata.keycode,
                       modifier: mod_en_reg ? map_rdata.modifier : '0,
                       pressed:  ev_pressed_reg};

    assign key_we    = (state_reg == ST_CLEAR) || key_change;
    assign key_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : ev_key_addr_reg;
    assign key_wdata = (state_reg == ST_CLEAR) ? '0 :
                       key_state_t'{down: ev_pressed_reg, stamp: now_reg};

    assign out_free = !evt_valid_reg || evt.ready;

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        issue_cnt_next   = issue_cnt_reg;
        ev_valid_next    = 1'b0;
        ring_head_next   = ring_we ? head_inc : ring_head_reg;
        ring_tail_next   = ring_tail_reg;
        evt_valid_next   = evt_valid_reg && !evt.ready;
        row_next         = row_reg;
        lvl_next         = lvl_reg;
        now_next         = now_reg;
        scan_end_next    = scan_end_reg;
        cols_next        = cols_reg;
        key_addr_next    = key_addr_reg;
        map_addr_next    = map_addr_reg;
        col_tag_next     = col_tag_reg;
        ev_col_next      = ev_col_reg;
        ev_pressed_next  = ev_pressed_reg;
        ev_key_addr_next = ev_key_addr_reg;
        pop_empty_next   = pop_empty_reg;
        evt_flag_next    = evt_flag_reg;
        evt_data_next    = evt_data_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == KEY_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire && (req.req_type == REQ_SCAN))
                begin
                    row_next       = req.row_index;
                    lvl_next       = req.col_levels;
                    now_next       = req.now_ms;
                    scan_end_next  = req.scan_end;
                    cols_next      = cols_lim[CNT_W-1:0];
                    key_addr_next  = key_base_full[KEY_AW-1:0];
                    map_addr_next  = map_prod[MAP_AW-1:0];
                    col_tag_next   = '0;
                    issue_cnt_next = '0;
                    if (row_in_use)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (req.scan_end)
                    begin
                        state_next = ST_POP_RD;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    ev_valid_next    = 1'b1;
                    ev_col_next      = col_tag_reg;
                    // columns past the readout shift in as released
                    ev_pressed_next  = !lvl_reg[0];
                    ev_key_addr_next = key_addr_reg;
                    lvl_next         = {1'b1, lvl_reg[LEVELS_W-1:1]};
                    issue_cnt_next   = issue_cnt_reg + 1'b1;
                    key_addr_next    = key_addr_reg + 1'b1;
                    map_addr_next    = map_addr_reg + 1'b1;
                    col_tag_next     = col_tag_reg + 1'b1;
                end
                else
                begin
                    state_next = scan_end_reg ? ST_POP_RD : ST_IDLE;
                end
            end
            ST_POP_RD:
            begin
                pop_empty_next = (ring_head_reg == ring_tail_reg);
                state_next     = ST_POP_WAIT;
            end
            ST_POP_WAIT:
            begin
                if (out_free)
                begin
                    evt_valid_next = 1'b1;
                    evt_flag_next  = !pop_empty_reg;
                    evt_data_next  = pop_empty_reg ? '0 : ring_rdata;
                    if (!pop_empty_reg)
                    begin
                        ring_tail_next = tail_inc;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            issue_cnt_reg <= '0;
            ev_valid_reg  <= 1'b0;
            ring_head_reg <= '0;
            ring_tail_reg <= '0;
            evt_valid_reg <= 1'b0;
            row_count_reg <= ROW_COUNT_RST;
            col_count_reg <= COL_COUNT_RST;
            debounce_reg  <= DEBOUNCE_RST;
            mod_en_reg    <= MOD_EN_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            issue_cnt_reg <= issue_cnt_next;
            ev_valid_reg  <= ev_valid_next;
            ring_head_reg <= ring_head_next;
            ring_tail_reg <= ring_tail_next;
            evt_valid_reg <= evt_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_ROW_COUNT:  row_count_reg <= cfg.data[CNT_CFG_W-1:0];
                    REG_COL_COUNT:  col_count_reg <= cfg.data[CNT_CFG_W-1:0];
                    REG_DEBOUNCE:   debounce_reg  <= cfg.data[TIME_W-1:0];
                    REG_MOD_ENABLE: mod_en_reg    <= cfg.data[0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg         <= row_next;
        lvl_reg         <= lvl_next;
        now_reg         <= now_next;
        scan_end_reg    <= scan_end_next;
        cols_reg        <= cols_next;
        key_addr_reg    <= key_addr_next;
        map_addr_reg    <= map_addr_next;
        col_tag_reg     <= col_tag_next;
        ev_col_reg      <= ev_col_next;
        ev_pressed_reg  <= ev_pressed_next;
        ev_key_addr_reg <= ev_key_addr_next;
        pop_empty_reg   <= pop_empty_next;
        evt_flag_reg    <= evt_flag_next;
        evt_data_reg    <= evt_data_next;
    end

    assign evt.valid          = evt_valid_reg;
    assign evt.event_valid    = evt_flag_reg;
    assign evt.event_row      = evt_data_reg.row;
    assign evt.event_col      = evt_data_reg.col;
    assign evt.event_keycode  = evt_data_reg.keycode;
    assign evt.event_modifier = evt_data_reg.modifier;
    assign evt.event_pressed  = evt_data_reg.pressed;

    a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid_reg |-> (state_reg == ST_SCAN))
        else $error("column evaluation outside a scan");

    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req.ready)
        else $error("request taken during key state clearing");

    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ring_we |=> (ring_head_reg != ring_tail_reg))
        else $error("ring empty right after a push");

    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push && ring_full) |=> $stable(ring_head_reg))
        else $error("ring head moved on a dropped event");

endmodule

// ===== tb/sv/kmdeq_event_checker.sv =====
`timescale 1ns / 1ps
// Event checker for the key matrix debounce core: tracks key state, keymap and
// the event ring from accepted words and compares each popped word.
// Depends on kmdeq_pkg, kmdeq_req_if, kmdeq_evt_if, kmdeq_cfg_if.
module kmdeq_event_checker (
    input  logic clk,
    input  logic rst_n,
    kmdeq_req_if req,
    kmdeq_evt_if evt,
    kmdeq_cfg_if cfg,
    output int   mismatches,
    output int   words_due
);
    import kmdeq_pkg::*;

    localparam int RING_SLOTS = QUEUE_DEPTH_DEF - 1;

    typedef struct packed {
        logic        present;
        scan_event_t ev;
    } pop_word_t;

    logic [CNT_CFG_W-1:0] row_cnt;
    logic [CNT_CFG_W-1:0] col_cnt;
    logic [TIME_W-1:0]    debounce;
    logic                 mod_en;
    logic                 key_down   [ROWS_MAX_DEF][COLS_MAX_DEF];
    logic [TIME_W-1:0]    changed_at [ROWS_MAX_DEF][COLS_MAX_DEF];
    map_entry_t           keymap     [MAP_DEPTH];
    scan_event_t          queued_events [$];
    pop_word_t            due_pops [$];
    int                   fails = 0;

    task automatic flag(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fails++;
    endtask

    task automatic cmp_field(input string name, input logic [CODE_W-1:0] got,
                             input logic [CODE_W-1:0] want);
        if (got !== want)
            flag($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Walk the columns of one row word, queue accepted changes, pop on scan end.
    task automatic predict_scan(input logic [ROW_W-1:0] row,
                                input logic [LEVELS_W-1:0] levels,
                                input logic [TIME_W-1:0] now, input logic pop);
        int                rows;
        int                cols;
        logic              down_now;
        logic [MAP_AW-1:0] addr;
        scan_event_t       ev;
        pop_word_t         w;
        rows = (row_cnt > ROWS_MAX_DEF) ? ROWS_MAX_DEF : int'(row_cnt);
        cols = (col_cnt > COLS_MAX_DEF) ? COLS_MAX_DEF : int'(col_cnt);
        if (int'(row) < rows) begin
            for (int c = 0; c < cols; c++) begin
                down_now = ~levels[c];
                if (down_now != key_down[row][c] &&
                    (now - changed_at[row][c]) >= debounce) begin
                    addr = MAP_AW'(int'(row) * cols + c);
                    key_down[row][c]   = down_now;
                    changed_at[row][c] = now;
                    ev.row      = row;
                    ev.col      = COL_W'(c);
                    ev.keycode  = keymap[addr].keycode;
                    ev.modifier = mod_en ? keymap[addr].modifier : '0;
                    ev.pressed  = down_now;
                    // full ring drops the event, key state still moves
                    if (queued_events.size() < RING_SLOTS)
                        queued_events.push_back(ev);
                end
            end
        end
        if (pop) begin
            w = '0;
            if (queued_events.size() > 0) begin
                w.present = 1'b1;
                w.ev      = queued_events.pop_front();
            end
            due_pops.push_back(w);
        end
    endtask

    task automatic check_pop();
        pop_word_t want;
        if (due_pops.size() == 0) begin
            flag("event word with none due");
            return;
        end
        want = due_pops.pop_front();
        cmp_field("event_valid", CODE_W'(evt.event_valid), CODE_W'(want.present));
        cmp_field("event_row", CODE_W'(evt.event_row), CODE_W'(want.ev.row));
        cmp_field("event_col", CODE_W'(evt.event_col), CODE_W'(want.ev.col));
        cmp_field("event_keycode", evt.event_keycode, want.ev.keycode);
        cmp_field("event_modifier", evt.event_modifier, want.ev.modifier);
        cmp_field("event_pressed", CODE_W'(evt.event_pressed), CODE_W'(want.ev.pressed));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            row_cnt  = ROW_COUNT_RST;
            col_cnt  = COL_COUNT_RST;
            debounce = DEBOUNCE_RST;
            mod_en   = MOD_EN_RST;
            for (int r = 0; r < ROWS_MAX_DEF; r++)
                for (int c = 0; c < COLS_MAX_DEF; c++) begin
                    key_down[r][c]   = 1'b0;
                    changed_at[r][c] = '0;
                end
            queued_events.delete();
            due_pops.delete();
        end
        else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_ROW_COUNT:  row_cnt  = cfg.data[CNT_CFG_W-1:0];
                    REG_COL_COUNT:  col_cnt  = cfg.data[CNT_CFG_W-1:0];
                    REG_DEBOUNCE:   debounce = cfg.data[TIME_W-1:0];
                    REG_MOD_ENABLE: mod_en   = cfg.data[0];
                    default: ;
                endcase
            end
            // popped word always stems from an earlier scan word
            if (evt.valid && evt.ready)
                check_pop();
            if (req.valid && req.ready) begin
                if (req.req_type == REQ_MAP) begin
                    keymap[req.map_index].keycode  = req.map_keycode;
                    keymap[req.map_index].modifier = req.map_modifier;
                end
                else
                    predict_scan(req.row_index, req.col_levels, req.now_ms, req.scan_end);
            end
        end
        mismatches <= fails;
        words_due  <= due_pops.size();
    end
endmodule

// ===== tb/sv/tb_key_matrix_debounce_event_queue_core.sv =====
`timescale 1ns / 1ps
// Top of the key matrix debounce core bench: clock, reset, scan and keymap
// stimulus, register phases and verdict. Depends on kmdeq_pkg, the channel
// interfaces, kmdeq_event_checker and key_matrix_debounce_event_queue_core.
module tb_key_matrix_debounce_event_queue_core;
    import kmdeq_pkg::*;

    localparam int SETTLE_CYCLES = 48;      // above scan plus pop latency
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 500;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   words_due;
    int   cycles = 0;

    kmdeq_req_if req ();
    kmdeq_evt_if evt ();
    kmdeq_cfg_if cfg ();

    key_matrix_debounce_event_queue_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .evt   (evt),
        .cfg   (cfg)
    );

    kmdeq_event_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .evt        (evt),
        .cfg        (cfg),
        .mismatches (mismatches),
        .words_due  (words_due)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    logic [LEVELS_W-1:0] row_levels [ROWS_MAX_DEF];
    logic [TIME_W-1:0]   clock_ms;
    int                  scan_rows = ROWS_MAX_DEF;
    int                  sent_pops = 0;
    int                  hold_asks = 0;
    bit                  steady    = 1'b0;

    // valid stays high after an accept; it drops only ahead of a gap
    task automatic put_word(input logic kind, input logic [ROW_W-1:0] row,
                            input logic [LEVELS_W-1:0] levels,
                            input logic [TIME_W-1:0] now, input logic last,
                            input logic [MAP_AW-1:0] idx,
                            input logic [CODE_W-1:0] kc, input logic [CODE_W-1:0] mc);
        int gap;
        if ($urandom_range(0, 19) == 0)
            steady = !steady;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.req_type     <= kind;
        req.row_index    <= row;
        req.col_levels   <= levels;
        req.now_ms       <= now;
        req.scan_end     <= last;
        req.map_index    <= idx;
        req.map_keycode  <= kc;
        req.map_modifier <= mc;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        if (kind == REQ_SCAN && last)
            sent_pops++;
    endtask

    task automatic scan(input logic [ROW_W-1:0] row, input logic [LEVELS_W-1:0] levels,
                        input logic [TIME_W-1:0] now, input logic last);
        put_word(REQ_SCAN, row, levels, now, last, MAP_AW'($urandom), CODE_W'($urandom),
                 CODE_W'($urandom));
    endtask

    task automatic map_wr(input logic [MAP_AW-1:0] idx, input logic [CODE_W-1:0] kc,
                          input logic [CODE_W-1:0] mc, input logic last);
        put_word(REQ_MAP, ROW_W'($urandom), LEVELS_W'($urandom), $urandom, last, idx, kc, mc);
    endtask

    // Quiet point: all pops in, then room for a scan word still in flight.
    task automatic settle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
    endtask

    // Upper data bits are noise; the registers keep only their own width.
    task automatic set_regs(input int rows, input int cols, input logic [TIME_W-1:0] deb,
                            input logic mod);
        put_reg(REG_ROW_COUNT, ($urandom & ~32'h1f) | rows);
        put_reg(REG_COL_COUNT, ($urandom & ~32'h1f) | cols);
        put_reg(REG_DEBOUNCE, deb);
        put_reg(REG_MOD_ENABLE, ($urandom & ~32'h1) | mod);
        cfg.valid <= 1'b0;
        scan_rows = (rows == 0) ? 1 : ((rows > ROWS_MAX_DEF) ? ROWS_MAX_DEF : rows);
    endtask

    task automatic directed();
        map_wr(8'hff, 8'hff, 8'hff, 1'b1);
        map_wr(8'h00, 8'h00, 8'h00, 1'b1);
        scan(4'd0, 16'hffff, 32'd1000, 1'b1);          // pop from an empty ring
        scan(4'd0, 16'h0000, 32'd1000, 1'b0);          // 16 presses overflow the ring
        scan(4'd15, 16'h7ffe, 32'd1001, 1'b0);         // dropped, state still moves
        scan(4'd15, 16'hffff, 32'd1003, 1'b1);         // inside debounce window
        scan(4'd15, 16'hffff, 32'd1006, 1'b1);         // exactly debounce apart
        scan(4'd0, 16'hffff, 32'hffff_ffff, 1'b0);
        scan(4'd0, 16'h0000, 32'h0000_0003, 1'b1);     // wrapped gap still too short
        scan(4'd0, 16'h0000, 32'h0000_0004, 1'b1);
        settle();
        set_regs(31, 0, 32'hffff_ffff, 1'b1);           // rows saturate, no columns
        scan(4'd3, 16'h0000, 32'd100, 1'b1);
        settle();
        set_regs(0, 16, 32'd0, 1'b1);                   // no rows in use
        scan(4'd0, 16'h0000, 32'd200, 1'b1);
        settle();
        set_regs(2, 31, 32'd0, 1'b1);
        scan(4'd1, 16'h00ff, 32'd300, 1'b0);
        scan(4'd5, 16'h0000, 32'd300, 1'b1);           // row out of range still pops
        repeat (6) scan(4'd0, 16'h0000, 32'd300, 1'b1);
    endtask

    // Mostly in-order row scans with sticky levels; some noise and keymap writes.
    task automatic random_phase(input int n_items);
        int                  row;
        int                  pick;
        logic [LEVELS_W-1:0] flips;
        row = 0;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                map_wr(MAP_AW'($urandom), CODE_W'($urandom), CODE_W'($urandom),
                       1'($urandom));
            else if (pick < 15)
                scan(ROW_W'($urandom), LEVELS_W'($urandom),
                     (pick < 10) ? $urandom : clock_ms, 1'($urandom));
            else
            begin
                flips = LEVELS_W'($urandom & $urandom & $urandom);
                if (pick > 96)
                    flips = LEVELS_W'($urandom);
                row_levels[row] ^= flips;
                clock_ms += $urandom_range(0, 3);
                scan(ROW_W'(row), row_levels[row], clock_ms, row == scan_rows - 1);
                row = (row + 1) % scan_rows;
            end
        end
    endtask

    initial
    begin : evt_sink
        int stall;
        int holds_done;
        bit quiet;
        holds_done = 0;
        quiet = 1'b0;
        evt.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                quiet = !quiet;
            if (hold_asks != holds_done)
            begin
                stall = LONG_HOLD;
                holds_done = hold_asks;
            end
            else
                stall = quiet ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                evt.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            evt.ready <= 1'b1;
            @(posedge clk);
            while (!evt.valid) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        rst_n            <= 1'b0;
        req.valid        <= 1'b0;
        req.req_type     <= REQ_SCAN;
        req.row_index    <= '0;
        req.col_levels   <= '1;
        req.now_ms       <= '0;
        req.scan_end     <= 1'b0;
        req.map_index    <= '0;
        req.map_keycode  <= '0;
        req.map_modifier <= '0;
        cfg.valid        <= 1'b0;
        cfg.index        <= REG_ROW_COUNT;
        cfg.data         <= '0;
        for (int r = 0; r < ROWS_MAX_DEF; r++)
            row_levels[r] = '1;
        clock_ms = 32'd2000;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every keymap entry written before any key can change
        for (int a = 0; a < MAP_DEPTH; a++)
            map_wr(MAP_AW'(a), CODE_W'($urandom), CODE_W'($urandom), 1'($urandom));
        directed();

        settle();
        set_regs(16, 16, 32'd5, 1'b1);
        random_phase(30);
        settle();
        set_regs(1, 16, 32'd0, 1'b1);
        hold_asks++;                    // sink stalls, ring and input back up
        steady = 1'b1;
        random_phase(30);
        settle();
        set_regs(4, 8, 32'd3, 1'b0);
        random_phase(25);
        settle();
        set_regs(31, 31, 32'd2, 1'b1);
        random_phase(25);
        settle();
        set_regs(0, 5, 32'd0, 1'b1);
        random_phase(15);
        settle();
        set_regs(16, 1, 32'hffff_ffff, 1'b1);
        clock_ms = 32'hffff_ffc0;
        random_phase(50);
        settle();
        set_regs(3, 16, 32'd0, 1'b0);
        random_phase(25);
        settle();
        set_regs(8, 12, 32'd10, 1'b1);
        random_phase(25);
        settle();
        set_regs(2, 4, 32'd1, 1'b1);
        random_phase(20);
        settle();
        set_regs(16, 16, 32'd0, 1'b1);
        random_phase(20);
        while (sent_pops < 60)
            random_phase(10);

        settle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
